// ===== sv/lmmr_pkg.sv =====
// Shared types and codes for the longest-match multi-pattern replacer.
package lmmr_pkg;

	// Request kinds on the input channel.
	localparam logic [2:0] KIND_PAT_BYTE = 3'd0;
	localparam logic [2:0] KIND_REP_BYTE = 3'd1;
	localparam logic [2:0] KIND_SET_LEN  = 3'd2;
	localparam logic [2:0] KIND_TEXT     = 3'd3;
	localparam logic [2:0] KIND_END      = 3'd4;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RD,
		ST_CMP,
		ST_RESOLVE,
		ST_ERD,
		ST_EMIT,
		ST_SHIFT,
		ST_FINISH
	} state_t;

	// Table write strobes.
	typedef struct packed {
		logic pat_we;
		logic rep_we;
		logic len_we;
	} tbl_wr_t;

endpackage

// ===== sv/longest_match_multi_replace.sv =====
// Top level: window, match sequencer with a shared byte comparator, and output stage.
// Decision: a text byte that fills the window, or end of text, starts a scan of the slots,
// comparing pattern bytes one by one; the winner's replacement bytes and consumed bytes follow.
// Throughput: one request at a time, stalled while busy; the single byte comparator and the
// one read port of each table memory set the rate. Table writes and non-filling text stay idle.
// Reset: arst_n clears the window count, slot lengths, sequencer and output valid.
module longest_match_multi_replace #(
	parameter int SLOTS   = 8,
	parameter int MAX_PAT = 8,
	parameter int MAX_REP = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_stall,
	input  logic [2:0] kind,
	input  logic [2:0] slot,
	input  logic [2:0] offset,
	input  logic [7:0] value,
	input  logic [3:0] pattern_length,
	input  logic [3:0] replacement_length,
	output logic       dst_valid,
	input  logic       dst_stall,
	output logic [7:0] out_byte,
	output logic       last
);
	import lmmr_pkg::*;

	localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int IW  = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;
	localparam int JW  = (MAX_REP > 1) ? $clog2(MAX_REP) : 1;
	localparam int PAW = (SLOTS*MAX_PAT > 1) ? $clog2(SLOTS*MAX_PAT) : 1;
	localparam int RAW = (SLOTS*MAX_REP > 1) ? $clog2(SLOTS*MAX_REP) : 1;
	localparam int CW  = $clog2(MAX_PAT+1);
	localparam int RLW = $clog2(MAX_REP+1);

	state_t state_q, state_d;

	logic [7:0]     win_q [MAX_PAT];
	logic [CW-1:0]  cnt_q;
	logic [SW-1:0]  s_q;
	logic [IW-1:0]  i_q;
	logic [JW-1:0]  j_q;
	logic [CW-1:0]  best_len_q;
	logic [SW-1:0]  best_slot_q;
	logic [CW-1:0]  used_q;
	logic [RLW-1:0] rl_q;
	logic           drain_q;
	logic [7:0]     pend_q;
	logic           pend_v_q;
	logic           dst_valid_q;
	logic [7:0]     out_byte_q;
	logic           last_q;

	tbl_wr_t        wr;
	logic [PAW-1:0] wr_pat_addr, pat_raddr;
	logic [RAW-1:0] wr_rep_addr, rep_raddr;
	logic [CW-1:0]  wr_plen;
	logic [RLW-1:0] wr_rlen;
	logic [7:0]     pat_rdata, rep_rdata;
	logic [SW-1:0]  len_slot;
	logic [CW-1:0]  plen;
	logic [RLW-1:0] rlen;

	logic accept, out_free, last_slot, skip_slot, byte_eq, pat_done, new_byte_ok;
	logic [7:0] new_byte;

	assign accept   = src_valid && !src_stall;
	assign out_free = !dst_valid_q || !dst_stall;

	// Table write decode: writes land only while the window is empty.
	always_comb begin
		wr = '0;
		if (accept && cnt_q == '0 && int'(slot) < SLOTS) begin
			wr.pat_we = (kind == KIND_PAT_BYTE) && (int'(offset) < MAX_PAT);
			wr.rep_we = (kind == KIND_REP_BYTE) && (int'(offset) < MAX_REP);
			wr.len_we = (kind == KIND_SET_LEN);
		end
	end

	assign wr_pat_addr = PAW'(int'(slot) * MAX_PAT + int'(offset));
	assign wr_rep_addr = RAW'(int'(slot) * MAX_REP + int'(offset));
	assign wr_plen = (int'(pattern_length) > MAX_PAT) ? CW'(MAX_PAT) : CW'(pattern_length);
	assign wr_rlen = (int'(replacement_length) > MAX_REP) ? RLW'(MAX_REP)
		: RLW'(replacement_length);

	// Read addresses for the shared compare and emit paths.
	assign pat_raddr = PAW'(int'(s_q) * MAX_PAT + int'(i_q));
	assign rep_raddr = RAW'(int'(best_slot_q) * MAX_REP + int'(j_q));
	assign len_slot  = (state_q == ST_RESOLVE) ? best_slot_q : s_q;

	lmmr_tables #(
		.SLOTS(SLOTS), .MAX_PAT(MAX_PAT), .MAX_REP(MAX_REP),
		.SW(SW), .PAW(PAW), .RAW(RAW), .LW(CW), .RLW(RLW)
	) u_tables (
		.clk(clk), .arst_n(arst_n), .wr(wr),
		.wr_pat_addr(wr_pat_addr), .wr_rep_addr(wr_rep_addr),
		.wr_slot(SW'(slot)), .wr_byte(value), .wr_plen(wr_plen), .wr_rlen(wr_rlen),
		.pat_raddr(pat_raddr), .pat_rdata(pat_rdata),
		.rep_raddr(rep_raddr), .rep_rdata(rep_rdata),
		.len_slot(len_slot), .plen(plen), .rlen(rlen)
	);

	// Shared comparator and slot bookkeeping.
	assign last_slot = (int'(s_q) == SLOTS - 1);
	assign skip_slot = (plen == '0) || (plen > cnt_q);
	assign byte_eq   = (win_q[i_q] == pat_rdata);
	assign pat_done  = (int'(i_q) + 1 == int'(plen));
	assign new_byte  = (best_len_q != '0) ? rep_rdata : win_q[0];
	assign new_byte_ok = !pend_v_q || out_free;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (kind == KIND_TEXT && int'(cnt_q) + 1 >= MAX_PAT) begin
						state_d = ST_SCAN;
					end else if (kind == KIND_END && cnt_q != '0) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (!skip_slot) begin
					state_d = ST_RD;
				end else if (last_slot) begin
					state_d = ST_RESOLVE;
				end
			end
			ST_RD: state_d = ST_CMP;
			ST_CMP: begin
				if (byte_eq && !pat_done) begin
					state_d = ST_RD;
				end else if (last_slot) begin
					state_d = ST_RESOLVE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_RESOLVE: begin
				if (best_len_q == '0) begin
					state_d = ST_EMIT;
				end else if (rlen == '0) begin
					state_d = ST_SHIFT;
				end else begin
					state_d = ST_ERD;
				end
			end
			ST_ERD: state_d = ST_EMIT;
			ST_EMIT: begin
				if (new_byte_ok) begin
					if (best_len_q != '0 && int'(j_q) + 1 < int'(rl_q)) begin
						state_d = ST_ERD;
					end else begin
						state_d = ST_SHIFT;
					end
				end
			end
			ST_SHIFT: begin
				if (used_q == CW'(1)) begin
					if (drain_q && cnt_q != CW'(1)) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_FINISH: begin
				if (!pend_v_q || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Output decode.
	always_comb begin
		src_stall = (state_q != ST_IDLE);
		dst_valid = dst_valid_q;
		out_byte  = out_byte_q;
		last      = last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			s_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			best_len_q  <= '0;
			best_slot_q <= '0;
			used_q      <= '0;
			rl_q        <= '0;
			drain_q     <= 1'b0;
			pend_v_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					s_q        <= '0;
					best_len_q <= '0;
					drain_q    <= (kind == KIND_END);
					if (accept && kind == KIND_TEXT && int'(cnt_q) < MAX_PAT) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_SCAN: begin
					i_q <= '0;
					if (skip_slot && !last_slot) begin
						s_q <= s_q + SW'(1);
					end
				end
				ST_CMP: begin
					if (byte_eq && !pat_done) begin
						i_q <= i_q + IW'(1);
					end else begin
						if (byte_eq && plen >= best_len_q) begin
							best_len_q  <= plen;
							best_slot_q <= s_q;
						end
						if (!last_slot) begin
							s_q <= s_q + SW'(1);
						end
					end
				end
				ST_RESOLVE: begin
					j_q    <= '0;
					rl_q   <= rlen;
					used_q <= (best_len_q == '0) ? CW'(1) : best_len_q;
				end
				ST_EMIT: begin
					if (new_byte_ok) begin
						pend_v_q <= 1'b1;
						j_q      <= j_q + JW'(1);
					end
				end
				ST_SHIFT: begin
					cnt_q      <= cnt_q - CW'(1);
					used_q     <= used_q - CW'(1);
					s_q        <= '0;
					best_len_q <= '0;
				end
				ST_FINISH: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Window bytes: written at the fill count, shifted one byte per cycle.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && kind == KIND_TEXT && int'(cnt_q) < MAX_PAT) begin
			win_q[IW'(cnt_q)] <= value;
		end else if (state_q == ST_SHIFT) begin
			for (int k = 0; k < MAX_PAT - 1; k++) begin
				win_q[k] <= win_q[k+1];
			end
		end
	end

	// Pending byte: held back one step so the final byte can carry last.
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && new_byte_ok) begin
			pend_q <= new_byte;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (pend_v_q && out_free && (state_q == ST_EMIT || state_q == ST_FINISH)) begin
			dst_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			dst_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_v_q && out_free && (state_q == ST_EMIT || state_q == ST_FINISH)) begin
			out_byte_q <= pend_q;
			last_q     <= (state_q == ST_FINISH);
		end
	end

	// The window never holds more than MAX_PAT bytes.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= MAX_PAT)
		else $error("window count exceeds depth");

	// A winning match never covers more bytes than the window holds.
	a_best_fits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RESOLVE |-> best_len_q <= cnt_q)
		else $error("match longer than window");

	// No byte is left pending once the sequencer returns to idle.
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_v_q)
		else $error("pending byte lost at idle");

	// Every shift consumes a byte that is present.
	a_shift_ok: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHIFT |-> (used_q != '0 && cnt_q != '0))
		else $error("shift with nothing to consume");

endmodule

// ===== sv/lmmr_tables.sv =====
// Pattern and replacement byte memories plus the per-slot length registers.
module lmmr_tables #(
	parameter int SLOTS   = 8,
	parameter int MAX_PAT = 8,
	parameter int MAX_REP = 8,
	parameter int SW      = 3,
	parameter int PAW     = 6,
	parameter int RAW     = 6,
	parameter int LW      = 4,
	parameter int RLW     = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lmmr_pkg::tbl_wr_t wr,
	input  logic [PAW-1:0]    wr_pat_addr,
	input  logic [RAW-1:0]    wr_rep_addr,
	input  logic [SW-1:0]     wr_slot,
	input  logic [7:0]        wr_byte,
	input  logic [LW-1:0]     wr_plen,
	input  logic [RLW-1:0]    wr_rlen,
	input  logic [PAW-1:0]    pat_raddr,
	output logic [7:0]        pat_rdata,
	input  logic [RAW-1:0]    rep_raddr,
	output logic [7:0]        rep_rdata,
	input  logic [SW-1:0]     len_slot,
	output logic [LW-1:0]     plen,
	output logic [RLW-1:0]    rlen
);
	import lmmr_pkg::*;

	logic [7:0]     pat_mem [SLOTS*MAX_PAT];
	logic [7:0]     rep_mem [SLOTS*MAX_REP];
	logic [LW-1:0]  plen_q  [SLOTS];
	logic [RLW-1:0] rlen_q  [SLOTS];

	// Pattern memory: one write and one registered read port.
	always_ff @(posedge clk) begin
		if (wr.pat_we) begin
			pat_mem[wr_pat_addr] <= wr_byte;
		end
		pat_rdata <= pat_mem[pat_raddr];
	end

	// Replacement memory: one write and one registered read port.
	always_ff @(posedge clk) begin
		if (wr.rep_we) begin
			rep_mem[wr_rep_addr] <= wr_byte;
		end
		rep_rdata <= rep_mem[rep_raddr];
	end

	// Length registers start at zero so every slot is unused after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SLOTS; k++) begin
				plen_q[k] <= '0;
				rlen_q[k] <= '0;
			end
		end else if (wr.len_we) begin
			plen_q[wr_slot] <= wr_plen;
			rlen_q[wr_slot] <= wr_rlen;
		end
	end

	assign plen = plen_q[len_slot];
	assign rlen = rlen_q[len_slot];

endmodule

// ===== tb/longest_match_multi_replace_tb.sv =====
// Self-checking testbench for the longest-match multi-pattern replacer.
module longest_match_multi_replace_tb;
	import lmmr_pkg::*;

	localparam int SLOTS   = 8;
	localparam int MAX_PAT = 8;
	localparam int MAX_REP = 8;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 200;
	localparam int HOLD_CYCLES = 400;
	localparam logic [2:0] KIND_UNDEF_LO = 3'd5;
	localparam logic [2:0] KIND_UNDEF_HI = 3'd7;

	logic       clk;
	logic       arst_n;
	logic       src_valid;
	logic       src_stall;
	logic [2:0] kind;
	logic [2:0] slot;
	logic [2:0] offset;
	logic [7:0] value;
	logic [3:0] pattern_length;
	logic [3:0] replacement_length;
	logic       dst_valid;
	logic       dst_stall;
	logic [7:0] out_byte;
	logic       last;

	longest_match_multi_replace #(
		.SLOTS(SLOTS),
		.MAX_PAT(MAX_PAT),
		.MAX_REP(MAX_REP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.kind(kind),
		.slot(slot),
		.offset(offset),
		.value(value),
		.pattern_length(pattern_length),
		.replacement_length(replacement_length),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.out_byte(out_byte),
		.last(last)
	);

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} text_out_t;

	// One row of the directed table; typed rows carry their own expected output.
	typedef struct packed {
		logic [2:0] kind;
		logic [2:0] slot;
		logic [2:0] offset;
		logic [7:0] value;
		logic [3:0] plen;
		logic [3:0] rlen;
		logic       typed;
		logic       typed_one;
		logic [7:0] typed_byte;
	} dir_row_t;

	localparam int DIR_ROWS = 23;
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{KIND_END,      3'd0, 3'd0, 8'h00, 4'd0,  4'd0,  1'b1, 1'b0, 8'h00},
		'{KIND_UNDEF_LO, 3'd0, 3'd0, 8'h00, 4'd0,  4'd0,  1'b1, 1'b0, 8'h00},
		'{KIND_UNDEF_HI, 3'd7, 3'd7, 8'hFF, 4'd15, 4'd15, 1'b1, 1'b0, 8'h00},
		'{KIND_TEXT,     3'd7, 3'd7, 8'hFF, 4'd15, 4'd15, 1'b1, 1'b0, 8'h00},
		'{KIND_END,      3'd7, 3'd7, 8'hFF, 4'd15, 4'd15, 1'b1, 1'b1, 8'hFF},
		'{KIND_PAT_BYTE, 3'd0, 3'd0, 8'h61, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00},
		'{KIND_PAT_BYTE, 3'd0, 3'd1, 8'h62, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00},
		'{KIND_PAT_BYTE, 3'd1, 3'd0, 8'h61, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00},
		'{KIND_PAT_BYTE, 3'd7, 3'd0, 8'h61, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00},
		'{KIND_PAT_BYTE, 3'd7, 3'd7, 8'h00, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00},
		'{KIND_REP_BYTE, 3'd0, 3'd0, 8'h58, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00},
		'{KIND_REP_BYTE, 3'd1, 3'd0, 8'h59, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00},
		'{KIND_REP_BYTE, 3'd1, 3'd1, 8'h5A, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00},
		'{KIND_REP_BYTE, 3'd7, 3'd7, 8'hFF, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00},
		'{KIND_SET_LEN,  3'd0, 3'd0, 8'h00, 4'd2,  4'd1,  1'b0, 1'b0, 8'h00},
		'{KIND_SET_LEN,  3'd1, 3'd0, 8'h00, 4'd1,  4'd2,  1'b0, 1'b0, 8'h00},
		'{KIND_SET_LEN,  3'd7, 3'd0, 8'h00, 4'd1,  4'd0,  1'b0, 1'b0, 8'h00},
		'{KIND_TEXT,     3'd0, 3'd0, 8'h61, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00},
		'{KIND_TEXT,     3'd0, 3'd0, 8'h62, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00},
		'{KIND_PAT_BYTE, 3'd0, 3'd0, 8'h00, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00},
		'{KIND_SET_LEN,  3'd0, 3'd0, 8'h00, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00},
		'{KIND_TEXT,     3'd0, 3'd0, 8'h61, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00},
		'{KIND_END,      3'd0, 3'd0, 8'h00, 4'd0,  4'd0,  1'b0, 1'b0, 8'h00}
	};

	// Predictor state.
	logic [7:0] win_bytes [MAX_PAT];
	int         win_count;
	logic [7:0] pat_store [SLOTS*MAX_PAT];
	logic [7:0] rep_store [SLOTS*MAX_REP];
	bit         pat_written [SLOTS*MAX_PAT];
	bit         rep_written [SLOTS*MAX_REP];
	int         pat_len [SLOTS];
	int         rep_len [SLOTS];

	text_out_t  expected_text_q [$];
	int         errors;
	int         cycle_count;
	int         src_idle_pct;
	int         dst_stall_pct;
	bit         pressure_go;

	// Report one mismatch and count it.
	task automatic report(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		errors++;
	endtask

	// One match decision at the head of the window.
	function automatic void decide_head(ref logic [7:0] produced [$]);
		int best_len;
		int best_slot;
		int used;
		bit hit;
		best_len = 0;
		best_slot = 0;
		for (int s = 0; s < SLOTS; s++) begin
			if (pat_len[s] == 0 || pat_len[s] > win_count)
				continue;
			hit = 1'b1;
			for (int i = 0; i < pat_len[s]; i++)
				if (win_bytes[i] != pat_store[s*MAX_PAT+i])
					hit = 1'b0;
			if (hit && pat_len[s] >= best_len) begin
				best_len = pat_len[s];
				best_slot = s;
			end
		end
		if (best_len > 0) begin
			for (int i = 0; i < rep_len[best_slot]; i++)
				produced.push_back(rep_store[best_slot*MAX_REP+i]);
			used = best_len;
		end else begin
			produced.push_back(win_bytes[0]);
			used = 1;
		end
		for (int i = 0; i + used < win_count; i++)
			win_bytes[i] = win_bytes[i+used];
		win_count -= used;
	endfunction

	// Apply one accepted request; returns 1 when the request had any effect.
	function automatic bit rewrite_step(input logic [2:0] k, input logic [2:0] s,
			input logic [2:0] o, input logic [7:0] v, input logic [3:0] pl,
			input logic [3:0] rl, input bit push);
		logic [7:0] produced [$];
		bit useful;
		useful = 1'b0;
		case (k)
			KIND_PAT_BYTE: if (win_count == 0) begin
				pat_store[s*MAX_PAT+o] = v;
				pat_written[s*MAX_PAT+o] = 1'b1;
				useful = 1'b1;
			end
			KIND_REP_BYTE: if (win_count == 0) begin
				rep_store[s*MAX_REP+o] = v;
				rep_written[s*MAX_REP+o] = 1'b1;
				useful = 1'b1;
			end
			KIND_SET_LEN: if (win_count == 0) begin
				pat_len[s] = (pl > MAX_PAT) ? MAX_PAT : pl;
				rep_len[s] = (rl > MAX_REP) ? MAX_REP : rl;
				useful = 1'b1;
			end
			KIND_TEXT: begin
				if (win_count < MAX_PAT) begin
					win_bytes[win_count] = v;
					win_count++;
				end
				if (win_count >= MAX_PAT)
					decide_head(produced);
				useful = 1'b1;
			end
			KIND_END: begin
				while (win_count > 0)
					decide_head(produced);
				useful = 1'b1;
			end
			default: useful = 1'b0;
		endcase
		if (push)
			foreach (produced[i])
				expected_text_q.push_back('{produced[i], i == produced.size() - 1});
		return useful;
	endfunction

	// Number of bytes written from offset zero upward without a hole.
	function automatic int pat_prefix(input int s);
		int n;
		n = 0;
		while (n < MAX_PAT && pat_written[s*MAX_PAT+n])
			n++;
		return n;
	endfunction

	function automatic int rep_prefix(input int s);
		int n;
		n = 0;
		while (n < MAX_REP && rep_written[s*MAX_REP+n])
			n++;
		return n;
	endfunction

	// Offer one request, wait until it is taken, then update the predictor.
	task automatic send(input logic [2:0] k, input logic [2:0] s, input logic [2:0] o,
			input logic [7:0] v, input logic [3:0] pl, input logic [3:0] rl,
			input bit push, output bit useful);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(negedge clk);
		end
		src_valid <= 1'b1;
		kind <= k;
		slot <= s;
		offset <= o;
		value <= v;
		pattern_length <= pl;
		replacement_length <= rl;
		do
			@(posedge clk);
		while (src_stall);
		useful = rewrite_step(k, s, o, v, pl, rl, push);
	endtask

	// Random request with random unused fields.
	task automatic send_rand(input logic [2:0] k, input logic [2:0] s, input logic [2:0] o,
			input logic [7:0] v, input logic [3:0] pl, input logic [3:0] rl,
			output bit useful);
		send(k, s, o, v, pl, rl, 1'b1, useful);
	endtask

	// Program one slot: pattern bytes, replacement bytes, then its lengths.
	task automatic program_slot(inout int count);
		int s;
		int np;
		int nr;
		int pl;
		int rl;
		bit u;
		s = $urandom_range(0, SLOTS - 1);
		np = ($urandom_range(0, 4) == 0) ? MAX_PAT : $urandom_range(1, 3);
		nr = ($urandom_range(0, 4) == 0) ? MAX_REP : $urandom_range(0, 3);
		for (int i = 0; i < np; i++) begin
			send_rand(KIND_PAT_BYTE, 3'(s), 3'(i), 8'($urandom_range(0, 3) == 0 ?
				$urandom_range(0, 255) : $urandom_range(8'h61, 8'h64)),
				4'($urandom), 4'($urandom), u);
			count += u;
		end
		for (int i = 0; i < nr; i++) begin
			send_rand(KIND_REP_BYTE, 3'(s), 3'(i), 8'($urandom_range(0, 255)),
				4'($urandom), 4'($urandom), u);
			count += u;
		end
		pl = $urandom_range(0, pat_prefix(s));
		if (pat_prefix(s) == MAX_PAT && $urandom_range(0, 1))
			pl = $urandom_range(MAX_PAT, 15);
		rl = $urandom_range(0, rep_prefix(s));
		if (rep_prefix(s) == MAX_REP && $urandom_range(0, 1))
			rl = $urandom_range(MAX_REP, 15);
		send_rand(KIND_SET_LEN, 3'(s), 3'($urandom), 8'($urandom), 4'(pl), 4'(rl), u);
		count += u;
	endtask

	// A run of text, often built from a stored pattern, sometimes closed by end of text.
	task automatic text_burst(inout int count);
		int s;
		int n;
		bit u;
		s = $urandom_range(0, SLOTS - 1);
		if (pat_len[s] > 0 && $urandom_range(0, 2) != 0) begin
			n = $urandom_range(1, pat_len[s]);
			if ($urandom_range(0, 3) != 0)
				n = pat_len[s];
			for (int i = 0; i < n; i++) begin
				send_rand(KIND_TEXT, 3'($urandom), 3'($urandom), pat_store[s*MAX_PAT+i],
					4'($urandom), 4'($urandom), u);
				count += u;
			end
		end
		n = $urandom_range(0, 6);
		for (int i = 0; i < n; i++) begin
			send_rand(KIND_TEXT, 3'($urandom), 3'($urandom), 8'($urandom_range(0, 1) ?
				$urandom_range(0, 255) : $urandom_range(8'h61, 8'h64)),
				4'($urandom), 4'($urandom), u);
			count += u;
		end
		if ($urandom_range(0, 1)) begin
			send_rand(KIND_END, 3'($urandom), 3'($urandom), 8'($urandom), 4'($urandom),
				4'($urandom), u);
			count += u;
		end
	endtask

	// Ignored kinds, pattern or replacement bytes, and length writes while text is pending.
	task automatic noise(inout int count);
		bit u;
		case ($urandom_range(0, 2))
			0: send_rand(3'($urandom_range(KIND_UNDEF_LO, KIND_UNDEF_HI)), 3'($urandom),
				3'($urandom), 8'($urandom), 4'($urandom), 4'($urandom), u);
			1: send_rand($urandom_range(0, 1) ? KIND_PAT_BYTE : KIND_REP_BYTE, 3'($urandom),
				3'($urandom), 8'($urandom), 4'($urandom), 4'($urandom), u);
			default: if (win_count != 0)
				send_rand(KIND_SET_LEN, 3'($urandom), 3'($urandom), 8'($urandom),
					4'($urandom), 4'($urandom), u);
			else
				u = 1'b0;
		endcase
		count += u;
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle counter and timeout.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("longest_match_multi_replace_tb: errors");
			$finish;
		end
	end

	// Receiver stall, with one long hold-off counted here.
	initial begin : receiver
		int hold_left;
		bit hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		dst_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (pressure_go && !hold_used) begin
				hold_left = HOLD_CYCLES;
				hold_used = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				dst_stall <= 1'b1;
			end else begin
				dst_stall <= ($urandom_range(0, 99) < dst_stall_pct);
			end
		end
	end

	// Compare each accepted output byte with the oldest expectation.
	always @(posedge clk) begin
		text_out_t want;
		if (arst_n && dst_valid && !dst_stall) begin
			if (expected_text_q.size() == 0) begin
				report($sformatf("unexpected byte %02h last %0b", out_byte, last));
			end else begin
				want = expected_text_q.pop_front();
				if (out_byte !== want.data)
					report($sformatf("out_byte %02h, want %02h", out_byte, want.data));
				if (last !== want.fin)
					report($sformatf("last %0b, want %0b", last, want.fin));
			end
		end
	end

	// Stimulus and end of run.
	initial begin : stimulus
		bit u;
		int count;
		int pick;
		errors = 0;
		src_idle_pct = 0;
		dst_stall_pct = 0;
		pressure_go = 1'b0;
		win_count = 0;
		for (int i = 0; i < SLOTS; i++) begin
			pat_len[i] = 0;
			rep_len[i] = 0;
		end
		for (int i = 0; i < SLOTS*MAX_PAT; i++) begin
			pat_written[i] = 1'b0;
			rep_written[i] = 1'b0;
		end
		src_valid = 1'b0;
		kind = KIND_TEXT;
		slot = '0;
		offset = '0;
		value = '0;
		pattern_length = '0;
		replacement_length = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table.
		for (int r = 0; r < DIR_ROWS; r++) begin
			send(DIR_TABLE[r].kind, DIR_TABLE[r].slot, DIR_TABLE[r].offset,
				DIR_TABLE[r].value, DIR_TABLE[r].plen, DIR_TABLE[r].rlen,
				!DIR_TABLE[r].typed, u);
			if (DIR_TABLE[r].typed && DIR_TABLE[r].typed_one)
				expected_text_q.push_back('{DIR_TABLE[r].typed_byte, 1'b1});
		end

		// Random phases with different idling; the first one also holds the receiver off.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin src_idle_pct = 0;  dst_stall_pct = 0;  pressure_go = 1'b1; end
				1: begin src_idle_pct = 79; dst_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  dst_stall_pct = 79; end
				default: begin src_idle_pct = 7; dst_stall_pct = 7; end
			endcase
			count = 0;
			while (count < 20) begin
				pick = $urandom_range(0, 99);
				if (pick < 30) begin
					if (win_count != 0) begin
						send_rand(KIND_END, 3'($urandom), 3'($urandom), 8'($urandom),
							4'($urandom), 4'($urandom), u);
						count += u;
					end
					program_slot(count);
				end else if (pick < 88) begin
					text_burst(count);
				end else begin
					noise(count);
				end
			end
		end
		send_rand(KIND_END, 3'($urandom), 3'($urandom), 8'($urandom), 4'($urandom),
			4'($urandom), u);
		@(negedge clk);
		src_valid <= 1'b0;

		while (expected_text_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_text_q.size() != 0)
			report("expected bytes left over");
		if (errors == 0)
			$display("longest_match_multi_replace_tb: clean");
		else
			$display("longest_match_multi_replace_tb: errors");
		$finish;
	end

endmodule

// ===== longest_match_multi_replace.f =====
sv/lmmr_pkg.sv
sv/lmmr_tables.sv
sv/longest_match_multi_replace.sv
tb/longest_match_multi_replace_tb.sv
